// File: rtl/scoi_pkg.sv
`default_nettype none

package scoi_pkg;

   // Pin count registers that exist; cards above this count have no pins.
   localparam int PIN_REGS = 4;

   // Widths fixed by the register and request fields.
   localparam int COUNT_W  = 3;
   localparam int PINS_W   = 7;
   localparam int SUM_W    = 6;   // up to four cards of fifteen bytes each
   localparam int GBYTE_W  = 7;   // global byte of a pin, up to sixty
   localparam int CSR_IDX_W = 3;

   // Command queue between front and back: two entries, one pointer bit.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CARD_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PINS_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PINS_B     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PINS_C     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PINS_D     = 3'd4;

   // Request type codes.
   localparam logic [1:0] REQ_SET   = 2'd0;
   localparam logic [1:0] REQ_FLUSH = 2'd1;
   localparam logic [1:0] REQ_TEST  = 2'd2;

   typedef enum logic [1:0] {
      CMD_SET,
      CMD_FLUSH,
      CMD_TEST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [GBYTE_W-1:0]   gbyte;
      logic [2:0]           bit_at;
      logic                 level;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/scoi_front.sv
`default_nettype none

module scoi_front #(
   parameter int MAX_CARD_SLOTS  = 4,
   parameter int MAX_CHAIN_BYTES = 8,
   parameter int TOTAL_W         = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [scoi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [scoi_pkg::PINS_W-1:0]   csr_data,
   input  wire logic                          push,
   input  wire logic [1:0]                    req_type,
   input  wire logic [2:0]                    req_card_number,
   input  wire logic [7:0]                    req_pin_number,
   input  wire logic                          req_pin_level,
   input  wire logic                          q_full,
   output logic                               q_push,
   output scoi_pkg::cmd_type                  q_cmd,
   output logic                               cfg_clear,
   output logic [TOTAL_W-1:0]                 total
);
   import scoi_pkg::*;

   logic [COUNT_W-1:0] card_count_ff, card_count_in;
   logic [PINS_W-1:0]  pins_ff [PIN_REGS];
   logic [PINS_W-1:0]  pins_in [PIN_REGS];

   logic [3:0]         cards_n;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   offset;
   logic [PINS_W-1:0]  card_pins;
   logic [2:0]         card_m1;
   logic [7:0]         pin_m1;
   logic [GBYTE_W-1:0] gbyte;
   logic               located;
   logic               take;

   always_comb begin
      card_count_in = card_count_ff;
      pins_in       = pins_ff;
      cfg_clear     = 1'b0;
      if (csr_write) begin
         priority if (csr_index == CSR_CARD_COUNT) begin
            card_count_in = csr_data[COUNT_W-1:0];
            cfg_clear     = 1'b1;
         end else if (csr_index == CSR_PINS_A || csr_index == CSR_PINS_B ||
                      csr_index == CSR_PINS_C || csr_index == CSR_PINS_D) begin
            pins_in[2'(csr_index - CSR_PINS_A)] = csr_data;
            cfg_clear = 1'b1;
         end else begin
            cfg_clear = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_count_ff <= '0;
         for (int i = 0; i < PIN_REGS; i++) begin
            pins_ff[i] <= '0;
         end
      end else begin
         card_count_ff <= card_count_in;
         pins_ff       <= pins_in;
      end
   end

   // Chain length and the byte offset of the addressed card.
   always_comb begin
      cards_n = (4'(card_count_ff) < 4'(MAX_CARD_SLOTS)) ? 4'(card_count_ff)
                                                         : 4'(MAX_CARD_SLOTS);
      sum    = '0;
      offset = '0;
      for (int i = 0; i < PIN_REGS; i++) begin
         if (i < int'(cards_n)) begin
            sum = sum + SUM_W'(pins_ff[i][PINS_W-1:3]);
         end
         if (i + 1 < int'(req_card_number)) begin
            offset = offset + SUM_W'(pins_ff[i][PINS_W-1:3]);
         end
      end
      total = (7'(sum) < 7'(MAX_CHAIN_BYTES)) ? TOTAL_W'(sum)
                                               : TOTAL_W'(MAX_CHAIN_BYTES);
   end

   always_comb begin
      card_m1   = req_card_number - 3'd1;
      card_pins = (4'(card_m1) < 4'(PIN_REGS)) ? pins_ff[card_m1[1:0]] : '0;
      pin_m1    = req_pin_number - 8'd1;
      gbyte     = GBYTE_W'(offset) + GBYTE_W'(pin_m1[7:3]);
      located   = (req_card_number != 3'd0) && (4'(req_card_number) <= cards_n) &&
                  (req_pin_number != 8'd0) && (pin_m1 < 8'(card_pins)) &&
                  (8'(gbyte) < 8'(total));
   end

   always_comb begin
      q_cmd.gbyte  = gbyte;
      q_cmd.bit_at = pin_m1[2:0];
      q_cmd.level  = req_pin_level;
      q_cmd.kind   = CMD_SET;
      take         = 1'b0;
      unique case (req_type)
         REQ_SET: begin
            q_cmd.kind = CMD_SET;
            take       = located;
         end
         REQ_FLUSH: begin
            q_cmd.kind = CMD_FLUSH;
            take       = 1'b1;
         end
         REQ_TEST: begin
            q_cmd.kind = CMD_TEST;
            take       = located;
         end
         default: begin
            take = 1'b0;
         end
      endcase
      // An empty chain makes every request a no-op.
      q_push = push && !q_full && take && (total != '0);
   end

endmodule

`default_nettype wire

// File: rtl/scoi_cmd_queue.sv
`default_nettype none

module scoi_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_push,
   input  wire scoi_pkg::cmd_type q_cmd,
   input  wire logic              q_pop,
   output logic                   q_full,
   output logic                   q_empty,
   output scoi_pkg::cmd_type      q_head
);
   import scoi_pkg::*;

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = slot_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   // The pointers wrap by overflow since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/scoi_back.sv
`default_nettype none

module scoi_back #(
   parameter int MAX_CHAIN_BYTES = 8,
   parameter int TOTAL_W         = 4,
   parameter int IDX_W           = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cfg_clear,
   input  wire logic [TOTAL_W-1:0] total,
   input  wire logic              q_empty,
   input  wire scoi_pkg::cmd_type q_head,
   output logic                   q_pop,
   output logic                   empty,
   input  wire logic              pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_byte
);
   import scoi_pkg::*;

   localparam int CMP_W = TOTAL_W + 1;

   back_state_type state_ff, state_in;

   logic [7:0]       image_ff [MAX_CHAIN_BYTES];
   logic             dirty_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic             test_mode_ff;
   logic [IDX_W-1:0] tbyte_ff;
   logic [2:0]       tbit_ff;
   logic             tlevel_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;

   logic             set_fire;
   logic             flush_go;
   logic             test_go;
   logic             emit_fire;
   logic             slot_free;
   logic             is_last;
   logic [7:0]       pos_wide;
   logic [IDX_W-1:0] head_idx;
   logic [IDX_W-1:0] rd_idx;
   logic [7:0]       rd_byte;
   logic [7:0]       set_byte;
   logic [7:0]       emit_byte;

   // Image byte of the head command: the byte order is reversed.
   assign pos_wide  = 8'(total) - 8'd1 - 8'(q_head.gbyte);
   assign head_idx  = pos_wide[IDX_W-1:0];
   assign slot_free = !out_valid_ff || pop;
   assign is_last   = (CMP_W'(cnt_ff) + CMP_W'(1)) == CMP_W'(total);
   assign rd_idx    = (state_ff == BK_EMIT) ? cnt_ff : head_idx;
   assign rd_byte   = image_ff[rd_idx];

   always_comb begin
      if (q_head.level) begin
         set_byte = rd_byte | (8'd1 << q_head.bit_at);
      end else begin
         set_byte = rd_byte & ~(8'd1 << q_head.bit_at);
      end
      if (test_mode_ff) begin
         emit_byte = (cnt_ff == tbyte_ff && tlevel_ff) ? (8'd1 << tbit_ff) : 8'd0;
      end else begin
         emit_byte = rd_byte;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && ((q_head.kind == CMD_FLUSH && dirty_ff) ||
                             q_head.kind == CMD_TEST)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (slot_free && is_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      set_fire  = 1'b0;
      flush_go  = 1'b0;
      test_go   = 1'b0;
      emit_fire = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_head.kind)
                  CMD_SET:   set_fire = 1'b1;
                  CMD_FLUSH: flush_go = dirty_ff;
                  CMD_TEST:  test_go  = 1'b1;
                  default:   set_fire = 1'b0;
               endcase
            end
         end
         BK_EMIT: begin
            emit_fire = slot_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         dirty_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHAIN_BYTES; i++) begin
            image_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (emit_fire) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
         // A configuration write wins over any image or dirty update.
         if (cfg_clear) begin
            dirty_ff <= 1'b1;
            for (int i = 0; i < MAX_CHAIN_BYTES; i++) begin
               image_ff[i] <= '0;
            end
         end else begin
            if (set_fire) begin
               image_ff[head_idx] <= set_byte;
               if (set_byte != rd_byte) begin
                  dirty_ff <= 1'b1;
               end
            end
            if (flush_go) begin
               dirty_ff <= 1'b0;
            end
            if (test_go) begin
               dirty_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (flush_go || test_go) begin
         cnt_ff       <= '0;
         test_mode_ff <= test_go;
         tbyte_ff     <= head_idx;
         tbit_ff      <= q_head.bit_at;
         tlevel_ff    <= q_head.level;
      end else if (emit_fire) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
      if (emit_fire) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= is_last;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

`ifndef SYNTHESIS
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && is_last) |=> (state_ff == BK_IDLE))
      else $error("emission did not end after the last byte");

   a_test_marks_dirty: assert property (@(posedge clock) disable iff (reset)
      test_go |=> dirty_ff)
      else $error("test request left the image clean");

   a_clear_marks_dirty: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> dirty_ff)
      else $error("configuration write left the image clean");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> (state_ff == BK_EMIT) && (!out_valid_ff || pop))
      else $error("byte emitted over a waiting result");
`endif

endmodule

`default_nettype wire

// File: rtl/shift_chain_output_image_top.sv
// Shift chain output image: keeps the byte image of a chain of shift-register
// output cards and produces the bytes to shift out.
// Requests enter on a queue-like port: a request is taken at a rising edge
// with push high and full low. Results leave the same way: the oldest byte
// sits on rsp_out_byte and rsp_last_byte while empty is low and is taken at
// an edge with pop high. rsp_last_byte marks the final byte of a transfer.
// A set request updates the image straight from the queue head. A flush of a
// dirty image or a test request first moves the back end to its emit state
// and then emits the chain bytes in order; the rate is set by the single
// output register that the back end fills one byte a cycle while the receiver
// pops. With the back end idle, a request passes through the command queue
// and the emit state before its first byte reaches the output register.
// Requests pass through a two-entry command queue, so the front keeps taking
// requests while the back end is emitting. When the receiver stalls, the
// output register holds its byte, the back end waits, the queue fills and
// full rises. Requests that cannot take effect are taken and dropped.
// Configuration is written through csr_write, csr_index and csr_data with no
// wait; a write to a known register clears the image and marks it dirty.
// Reset is synchronous: it clears the control state, configuration and image,
// and marks the image dirty, so the first flush repaints the whole chain.
`default_nettype none

module shift_chain_output_image_top #(
   parameter int MAX_CARD_SLOTS  = 4,
   parameter int MAX_CHAIN_BYTES = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [scoi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [scoi_pkg::PINS_W-1:0]    csr_data,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [1:0]                     req_type,
   input  wire logic [2:0]                     req_card_number,
   input  wire logic [7:0]                     req_pin_number,
   input  wire logic                           req_pin_level,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last_byte
);
   import scoi_pkg::*;

   // Width of the chain length and of an index into the image.
   localparam int TOTAL_W = $clog2(MAX_CHAIN_BYTES + 1);
   localparam int IDX_W   = (MAX_CHAIN_BYTES > 1) ? $clog2(MAX_CHAIN_BYTES) : 1;

   logic               q_push;
   cmd_type            q_cmd;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   cmd_type            q_head;
   logic               cfg_clear;
   logic [TOTAL_W-1:0] total;

   // The front holds the configuration, computes the chain layout and turns
   // each request into a located command or drops it.
   scoi_front #(
      .MAX_CARD_SLOTS  (MAX_CARD_SLOTS),
      .MAX_CHAIN_BYTES (MAX_CHAIN_BYTES),
      .TOTAL_W         (TOTAL_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push            (push),
      .req_type        (req_type),
      .req_card_number (req_card_number),
      .req_pin_number  (req_pin_number),
      .req_pin_level   (req_pin_level),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (q_cmd),
      .cfg_clear       (cfg_clear),
      .total           (total)
   );

   scoi_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .q_full  (q_full),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // The back owns the image and the dirty flag and emits the bytes.
   scoi_back #(
      .MAX_CHAIN_BYTES (MAX_CHAIN_BYTES),
      .TOTAL_W         (TOTAL_W),
      .IDX_W           (IDX_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_clear     (cfg_clear),
      .total         (total),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // A request is refused only while the command queue is full.
   assign full = q_full;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

// Testbench for the shift chain output image block.
// The bench drives set, flush and test requests into the queue-like request
// port and pops chain bytes from the response port. A behavioral image of the
// card chain is kept here, and it is updated whenever the block takes a
// request or a register write. Every flush or test that should produce bytes
// appends them to a queue of expected chain bytes, and the response monitor
// compares each popped byte against the oldest entry of that queue.
// Inputs are driven at the falling clock edge; handshakes and outputs are
// sampled at the rising edge, so nothing depends on event ordering.
module testbench;

   import scoi_pkg::*;

   localparam int MAX_CARD_SLOTS  = 4;
   localparam int MAX_CHAIN_BYTES = 8;

   // Request code that the block must ignore.
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // Register indexes that hold no register.
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG_HIGH = 3'd7;

   // Cycles allowed for queued requests that produce no bytes to drain out
   // of the block before a register write. The command queue holds two
   // entries and a transfer emits at most MAX_CHAIN_BYTES chain bytes.
   localparam int SETTLE_CYCLES  = 24;
   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } chain_byte_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PINS_W-1:0]    csr_data;
   logic                 push;
   logic                 full;
   logic [1:0]           req_type;
   logic [2:0]           req_card_number;
   logic [7:0]           req_pin_number;
   logic                 req_pin_level;
   logic                 empty;
   logic                 pop;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last_byte;

   // Mirror of the block's configuration and image.
   logic [COUNT_W-1:0]   chain_cards;
   logic [PINS_W-1:0]    chain_pins [PIN_REGS];
   logic [7:0]           image_model [MAX_CHAIN_BYTES];
   logic                 image_dirty_model;

   // Chain bytes that the block still owes, oldest first.
   chain_byte_type       expected_bytes [$];

   int                   error_count;
   int                   idle_cycles;
   // When clear, neither side inserts idle cycles.
   bit                   idling;

   shift_chain_output_image_top #(
      .MAX_CARD_SLOTS (MAX_CARD_SLOTS),
      .MAX_CHAIN_BYTES(MAX_CHAIN_BYTES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_card_number(req_card_number),
      .req_pin_number (req_pin_number),
      .req_pin_level  (req_pin_level),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   // The clock has a period of 12 time units.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ------------------------------------------------------------------
   // Behavioral model of the chain image.
   // ------------------------------------------------------------------

   function automatic void reset_image_model();
      chain_cards = '0;
      foreach (chain_pins[i]) chain_pins[i] = '0;
      foreach (image_model[i]) image_model[i] = '0;
      // The first flush after reset always repaints the chain.
      image_dirty_model = 1'b1;
   endfunction

   // Cards in use, with the register clamped to the number of slots.
   function automatic int cards_in_chain();
      return (chain_cards < MAX_CARD_SLOTS) ? int'(chain_cards) : MAX_CARD_SLOTS;
   endfunction

   function automatic int pins_on_card(input int slot);
      return (slot < PIN_REGS) ? int'(chain_pins[slot]) : 0;
   endfunction

   // Only whole bytes of each card are part of the chain, and the total
   // saturates at the size of the image.
   function automatic int chain_length();
      int sum;
      sum = 0;
      for (int i = 0; i < cards_in_chain(); i++) sum += pins_on_card(i) / 8;
      return (sum < MAX_CHAIN_BYTES) ? sum : MAX_CHAIN_BYTES;
   endfunction

   // Maps a 1-based card and pin onto the reversed byte image. Returns zero
   // when the card or pin is out of range or the bit falls past the chain.
   function automatic bit locate_pin(input int card, input int pin, input int total,
                                     output int byte_at, output int bit_at);
      int offset;
      int global_bit;
      byte_at = 0;
      bit_at  = 0;
      if (card == 0 || card > cards_in_chain()) return 1'b0;
      if (pin == 0 || pin - 1 >= pins_on_card(card - 1)) return 1'b0;
      offset = 0;
      for (int i = 0; i + 1 < card; i++) offset += pins_on_card(i) / 8;
      global_bit = offset * 8 + (pin - 1);
      if (global_bit / 8 >= total) return 1'b0;
      byte_at = total - 1 - global_bit / 8;
      bit_at  = global_bit % 8;
      return 1'b1;
   endfunction

   function automatic void queue_transfer(input logic [7:0] bytes [MAX_CHAIN_BYTES],
                                          input int total);
      chain_byte_type entry;
      for (int i = 0; i < total; i++) begin
         entry.value = bytes[i];
         entry.last  = (i + 1 == total);
         expected_bytes.push_back(entry);
      end
   endfunction

   function automatic void apply_register_write(input logic [CSR_IDX_W-1:0] index,
                                                input logic [PINS_W-1:0] value);
      case (index)
         CSR_CARD_COUNT: chain_cards = value[COUNT_W-1:0];
         CSR_PINS_A:     chain_pins[0] = value;
         CSR_PINS_B:     chain_pins[1] = value;
         CSR_PINS_C:     chain_pins[2] = value;
         CSR_PINS_D:     chain_pins[3] = value;
         default:        return;
      endcase
      // Any change of the chain layout invalidates the image.
      foreach (image_model[i]) image_model[i] = '0;
      image_dirty_model = 1'b1;
   endfunction

   // Updates the image for one taken request and records the chain bytes
   // that the request must produce.
   function automatic void predict_chain_bytes(input logic [1:0] kind, input logic [2:0] card,
                                                input logic [7:0] pin, input logic level);
      int         total;
      int         byte_at;
      int         bit_at;
      logic [7:0] old_value;
      logic [7:0] new_value;
      logic [7:0] probe [MAX_CHAIN_BYTES];
      total = chain_length();
      // With an empty chain every request is dropped, dirty flag included.
      if (total == 0) return;
      case (kind)
         REQ_SET: begin
            if (!locate_pin(card, pin, total, byte_at, bit_at)) return;
            old_value = image_model[byte_at];
            new_value = old_value;
            new_value[bit_at] = level;
            image_model[byte_at] = new_value;
            if (new_value != old_value) image_dirty_model = 1'b1;
         end
         REQ_FLUSH: begin
            if (!image_dirty_model) return;
            queue_transfer(image_model, total);
            image_dirty_model = 1'b0;
         end
         REQ_TEST: begin
            if (!locate_pin(card, pin, total, byte_at, bit_at)) return;
            foreach (probe[i]) probe[i] = '0;
            probe[byte_at][bit_at] = level;
            // The stored image is untouched, but the chain must be repainted.
            image_dirty_model = 1'b1;
            queue_transfer(probe, total);
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   // Sends one request and waits until the block takes it. The push line is
   // left high so that back-to-back requests need no idle cycle.
   task automatic send_request(input logic [1:0] kind, input logic [2:0] card,
                               input logic [7:0] pin, input logic level);
      int gap;
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         push = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_type        = kind;
      req_card_number = card;
      req_pin_number  = pin;
      req_pin_level   = level;
      push            = 1'b1;
      do @(posedge clock); while (full);
      predict_chain_bytes(kind, card, pin, level);
   endtask

   // Brings the block to rest: no request pending, every expected byte
   // popped, and enough extra cycles for queued silent requests to finish.
   task automatic settle();
      @(negedge clock);
      push = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The request line is dropped first so that a request left pending by
   // the last send is not taken a second time.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [PINS_W-1:0] value);
      @(negedge clock);
      push      = 1'b0;
      csr_write = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      apply_register_write(index, value);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic configure_chain(input logic [PINS_W-1:0] count,
                                  input logic [PINS_W-1:0] pins_a,
                                  input logic [PINS_W-1:0] pins_b,
                                  input logic [PINS_W-1:0] pins_c,
                                  input logic [PINS_W-1:0] pins_d);
      settle();
      write_register(CSR_CARD_COUNT, count);
      write_register(CSR_PINS_A, pins_a);
      write_register(CSR_PINS_B, pins_b);
      write_register(CSR_PINS_C, pins_c);
      write_register(CSR_PINS_D, pins_d);
   endtask

   // Pin counts lean toward whole bytes so that most cards add to the chain.
   function automatic logic [PINS_W-1:0] random_pin_count();
      case ($urandom_range(0, 3))
         0, 1:    return PINS_W'($urandom_range(0, 8) * 8);
         2:       return PINS_W'($urandom_range(0, 127));
         default: return PINS_W'($urandom_range(0, 23));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Straight out of reset the chain has no cards, so nothing may come out,
   // not even from the pending repaint. A pin count alone does not help.
   task automatic test_empty_chain();
      send_request(REQ_FLUSH, 3'd1, 8'd1, 1'b1);
      write_register(CSR_PINS_A, 7'd64);
      send_request(REQ_SET, 3'd1, 8'd1, 1'b1);
      send_request(REQ_TEST, 3'd1, 8'd1, 1'b1);
      send_request(REQ_UNKNOWN, 3'd7, 8'd255, 1'b1);
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
   endtask

   // Two cards: the first holds two bytes, the second twelve pins of which
   // only the first byte is part of the chain.
   task automatic test_small_chain();
      configure_chain(7'd2, 7'd16, 7'd12, 7'd0, 7'd0);
      // The write left the image dirty, so the first flush repaints zeros.
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
      // A clean image produces nothing.
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
      send_request(REQ_SET, 3'd1, 8'd1, 1'b1);
      // Setting a bit that is already set is not a change.
      send_request(REQ_SET, 3'd1, 8'd1, 1'b1);
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
      send_request(REQ_SET, 3'd2, 8'd8, 1'b1);
      // Pin nine of card two lies in its partial byte, outside the chain.
      send_request(REQ_SET, 3'd2, 8'd9, 1'b1);
      // Bad pins and bad cards are dropped.
      send_request(REQ_SET, 3'd2, 8'd13, 1'b1);
      send_request(REQ_SET, 3'd1, 8'd0, 1'b1);
      send_request(REQ_SET, 3'd0, 8'd1, 1'b1);
      send_request(REQ_SET, 3'd3, 8'd1, 1'b1);
      send_request(REQ_TEST, 3'd7, 8'd255, 1'b1);
      // Tests show a single bit, or an all-zero chain with a low level.
      send_request(REQ_TEST, 3'd1, 8'd16, 1'b1);
      send_request(REQ_TEST, 3'd2, 8'd1, 1'b0);
      // A test leaves the image dirty, so the flush repaints it.
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
      send_request(REQ_SET, 3'd1, 8'd1, 1'b0);
      send_request(REQ_UNKNOWN, 3'd1, 8'd1, 1'b0);
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
   endtask

   // The widest setting: the card count is clamped and the chain saturates,
   // so the first card alone fills the whole image.
   task automatic test_saturated_chain();
      configure_chain(7'd7, 7'd127, 7'd127, 7'd127, 7'd127);
      send_request(REQ_SET, 3'd1, 8'd64, 1'b1);
      send_request(REQ_SET, 3'd1, 8'd65, 1'b1);
      send_request(REQ_SET, 3'd2, 8'd1, 1'b1);
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
      send_request(REQ_TEST, 3'd1, 8'd1, 1'b1);
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
      // A write to an index without a register leaves the image alone.
      settle();
      write_register(CSR_NO_REG_LOW, 7'h55);
      write_register(CSR_NO_REG_HIGH, 7'h2a);
      send_request(REQ_FLUSH, 3'd0, 8'd0, 1'b0);
   endtask

   // Random chain layouts followed by mostly well-formed requests, with
   // some requests of entirely random content mixed in.
   task automatic test_random_phase(input int item_count);
      int               roll;
      int               card_limit;
      int               pin_limit;
      logic [PINS_W-1:0] count;
      logic [1:0]       kind;
      logic [2:0]       card;
      logic [7:0]       pin;
      roll = $urandom_range(0, 11);
      count = (roll > 7) ? PINS_W'(4) : PINS_W'(roll);
      configure_chain(count, random_pin_count(), random_pin_count(),
                      random_pin_count(), random_pin_count());
      for (int n = 0; n < item_count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll >= 88) begin
            send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            kind = (roll < 45) ? REQ_SET : (roll < 72) ? REQ_FLUSH : REQ_TEST;
            card_limit = cards_in_chain();
            card = (card_limit == 0) ? 3'($urandom_range(0, 7))
                                     : 3'($urandom_range(1, card_limit));
            pin_limit = (card == 0) ? 0 : pins_on_card(card - 1);
            pin = (pin_limit == 0) ? 8'($urandom_range(0, 255))
                                   : 8'($urandom_range(1, pin_limit));
            send_request(kind, card, pin, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Response side.
   // ------------------------------------------------------------------

   // The receiver stalls in random bursts while idling is enabled.
   initial begin
      int burst;
      pop = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(negedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            pop = 1'b0;
            burst = $urandom_range(1, 6);
            repeat (burst - 1) @(negedge clock);
         end else begin
            pop = 1'b1;
         end
      end
   end

   // Every popped byte is checked against the oldest expected chain byte.
   always @(posedge clock) begin
      chain_byte_type wanted;
      if (!reset && pop && !empty) begin
         if (expected_bytes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected chain byte, expected none actual %02h last %0b",
                     $time, rsp_out_byte, rsp_last_byte);
         end else begin
            wanted = expected_bytes.pop_front();
            if (rsp_out_byte !== wanted.value) begin
               error_count++;
               $display("%0t: out_byte mismatch, expected %02h actual %02h",
                        $time, wanted.value, rsp_out_byte);
            end
            if (rsp_last_byte !== wanted.last) begin
               error_count++;
               $display("%0t: last_byte mismatch, expected %0b actual %0b",
                        $time, wanted.last, rsp_last_byte);
            end
         end
      end
   end

   // The run is stopped when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || csr_write) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      push            = 1'b0;
      req_type        = REQ_SET;
      req_card_number = '0;
      req_pin_number  = '0;
      req_pin_level   = 1'b0;
      error_count     = 0;
      idle_cycles     = 0;
      idling          = 1'b1;
      reset_image_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_chain();
      test_small_chain();
      test_saturated_chain();
      repeat (4) test_random_phase(21);
      // The last phase runs at full rate on both sides.
      idling = 1'b0;
      test_random_phase(21);

      @(negedge clock);
      push = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
